[sv/keyframe_vector_interpolator_assert.svh]
// assertion macros used by the checker file kvi_checker.sv
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_ASSERT_SVH
// same-cycle implication
`define KVI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define KVI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[sv/kvi_pkg.sv]
// ----------------------------------------------------------------------------
// kvi_pkg
// shared constants and types of the keyframe vector interpolator
// ----------------------------------------------------------------------------
package kvi_pkg;
   localparam int MAX_KEYS = 64;
   localparam int TAG_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int SLOT_W   = 6;
   localparam int SEG_W    = 6;
   localparam int CMP_W    = (TAG_W > SLOT_W) ? TAG_W : SLOT_W;
   localparam int FRAC_W   = 16;
   localparam int QUO_W    = FRAC_W + 1;

   typedef struct packed {
      logic [31:0] ktime;
      logic [31:0] kx;
      logic [31:0] ky;
      logic [31:0] kz;
   } key_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      key_type          key;
   } slot_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      key_type           key;
   } wr_type;
endpackage

[sv/kvi_cell.sv]
// ----------------------------------------------------------------------------
// kvi_cell
// one ring cell: holds a tagged key and passes it on every cycle
// ----------------------------------------------------------------------------
module kvi_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [kvi_pkg::TAG_W-1:0] reset_tag,
   input  kvi_pkg::slot_type       slot_in,
   input  kvi_pkg::wr_type         wr,
   output kvi_pkg::slot_type       slot_out
);
   logic [kvi_pkg::TAG_W-1:0] tag_ff;
   kvi_pkg::key_type          key_ff, key_in;
   logic                      hit;

   assign hit = wr.en &&
      (kvi_pkg::CMP_W'(slot_in.tag) == kvi_pkg::CMP_W'(wr.slot));
   assign key_in = hit ? wr.key : slot_in.key;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= reset_tag;
      end else begin
         tag_ff <= slot_in.tag;
      end
      key_ff <= key_in;
   end

   assign slot_out.tag = tag_ff;
   assign slot_out.key = key_ff;
endmodule

[sv/kvi_div.sv]
// ----------------------------------------------------------------------------
// kvi_div
// restoring divider for the segment factor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kvi_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [31:0]               num,
   input  logic [31:0]               den,
   output logic                      done,
   output logic [kvi_pkg::QUO_W-1:0] quo
);
   localparam int STEP_W = $clog2(kvi_pkg::FRAC_W + 1);

   logic [31:0]               rem_ff, rem_in, den_ff;
   logic [kvi_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      run_ff, run_in, done_ff, done_in;
   logic [32:0]               rem2;
   logic                      ge;

   assign rem2 = {rem_ff, 1'b0};
   assign ge   = rem2 >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         run_in  = 1'b1;
         step_in = STEP_W'(kvi_pkg::FRAC_W);
         quo_in  = kvi_pkg::QUO_W'(num >= den);
         rem_in  = (num >= den) ? num - den : num;
      end else if (run_ff) begin
         rem_in  = ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
         quo_in  = {quo_ff[kvi_pkg::QUO_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (go) begin
         den_ff <= den;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

[sv/keyframe_vector_interpolator.sv]
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator
// linear interpolation of an xyz vector between stored keyframes
// ----------------------------------------------------------------------------
// Request channel: a transaction is taken when start is high and busy low.
// req_action low writes one key into slot req_key_slot;
// busy stays low. req_action high queries at req_query_time and raises busy.
// Result channel: rsp_valid is high for one cycle with the vector, segment
// and fault flag; it cannot be held off, and busy is already low then.
// Keys live in a ring of cells that rotates by one place every cycle.
// A query waits for key 0 to reach the head, scans up to key_count - 1
// keys, passes the check cycle, runs the divider, then multiplies and adds
// per axis; the result strobe rises in the same cycle as busy falls.
// A single key ends the query right after alignment, a fault right after
// the check cycle.
// csr_we writes key_count at once; the user writes only while idle (not enforced).
// Reset sets key_count to 1 and clears control state; keys stay undefined.
module keyframe_vector_interpolator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_action,
   input  logic [kvi_pkg::SLOT_W-1:0] req_key_slot,
   input  logic [31:0]                req_key_time,
   input  logic signed [31:0]         req_key_x,
   input  logic signed [31:0]         req_key_y,
   input  logic signed [31:0]         req_key_z,
   input  logic [31:0]                req_query_time,
   input  logic                       csr_we,
   input  logic [6:0]                 csr_wdata,
   output logic                       rsp_valid,
   output logic signed [31:0]         rsp_out_x,
   output logic signed [31:0]         rsp_out_y,
   output logic signed [31:0]         rsp_out_z,
   output logic [kvi_pkg::SEG_W-1:0]  rsp_segment,
   output logic                       rsp_factor_fault
);
   localparam int N = kvi_pkg::MAX_KEYS;
   localparam int TW = kvi_pkg::TAG_W;
   localparam int CW = kvi_pkg::CNT_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ALIGN = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_MUL   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [6:0]         count_ff;
   logic [CW-1:0]      n_ff, n_eff;
   logic [31:0]        q_ff;
   logic [TW-1:0]      idx_ff, idx_in;
   kvi_pkg::key_type   prev_ff, k0_ff, k1_ff, s_ff, e_ff;
   logic [1:0]         ax_ff;
   logic signed [50:0] prod_ff;
   logic [31:0]        res_ff [3];
   logic               valid_ff, fault_ff, go_ff;
   logic [kvi_pkg::SEG_W-1:0] seg_ff;

   kvi_pkg::slot_type  ring [N];
   kvi_pkg::wr_type    wr;
   kvi_pkg::slot_type  head;

   logic signed [32:0] num, den;
   logic               ok;
   logic [31:0]        an, ad;
   logic               div_done;
   logic [kvi_pkg::QUO_W-1:0] quo;
   logic [31:0]        s_ax [3];
   logic [31:0]        e_ax [3];
   logic signed [32:0] d_ax;

   assign wr.en   = start && !busy && !req_action;
   assign wr.slot = req_key_slot;
   assign wr.key  = '{ktime: req_key_time, kx: req_key_x, ky: req_key_y, kz: req_key_z};

   for (genvar k = 0; k < N; k++) begin : g_cell
      kvi_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .reset_tag (TW'(k)),
         .slot_in   (ring[(k + 1) % N]),
         .wr        (wr),
         .slot_out  (ring[k])
      );
   end

   assign head = ring[0];

   always_comb begin
      if (count_ff == 7'd0) begin
         n_eff = CW'(1);
      end else if (32'(count_ff) > N) begin
         n_eff = CW'(N);
      end else begin
         n_eff = CW'(count_ff);
      end
   end

   assign num = $signed({1'b0, q_ff}) - $signed({1'b0, s_ff.ktime});
   assign den = $signed({1'b0, e_ff.ktime}) - $signed({1'b0, s_ff.ktime});
   assign ok  = (den > 0) ? (num >= 0 && num <= den) :
                (den < 0) ? (num <= 0 && num >= den) : 1'b0;
   assign an  = num[32] ? 32'(-num) : num[31:0];
   assign ad  = den[32] ? 32'(-den) : den[31:0];

   kvi_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (go_ff),
      .num   (an),
      .den   (ad),
      .done  (div_done),
      .quo   (quo)
   );

   assign s_ax[0] = s_ff.kx;
   assign s_ax[1] = s_ff.ky;
   assign s_ax[2] = s_ff.kz;
   assign e_ax[0] = e_ff.kx;
   assign e_ax[1] = e_ff.ky;
   assign e_ax[2] = e_ff.kz;

   always_comb begin
      unique case (ax_ff)
         2'd0: d_ax = $signed({e_ax[0][31], e_ax[0]}) - $signed({s_ax[0][31], s_ax[0]});
         2'd1: d_ax = $signed({e_ax[1][31], e_ax[1]}) - $signed({s_ax[1][31], s_ax[1]});
         2'd2: d_ax = $signed({e_ax[2][31], e_ax[2]}) - $signed({s_ax[2][31], s_ax[2]});
         default: d_ax = 33'sd0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_action) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (head.tag == TW'(0)) begin
               state_in = (n_ff == CW'(1)) ? ST_IDLE : ST_SCAN;
               idx_in   = TW'(0);
            end
         end
         ST_SCAN: begin
            if (q_ff < head.key.ktime) begin
               state_in = ST_DIV;
            end else if ((CW'(idx_ff) + CW'(2)) == n_ff) begin
               state_in = ST_DIV;
            end else begin
               idx_in = idx_ff + TW'(1);
            end
         end
         ST_DIV: begin
            if (!go_ff && !ok && !div_done && ax_ff == 2'd0) begin
               state_in = ST_IDLE;
            end else if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (ax_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 7'd1;
         valid_ff <= 1'b0;
         go_ff    <= 1'b0;
         ax_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         valid_ff <= 1'b0;
         go_ff    <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               ax_ff <= 2'd0;
            end
            ST_ALIGN: begin
               if (head.tag == TW'(0) && n_ff == CW'(1)) begin
                  valid_ff <= 1'b1;
               end
            end
            ST_SCAN: begin
               ax_ff <= 2'd0;
            end
            ST_DIV: begin
               if (ax_ff == 2'd0) begin
                  ax_ff <= 2'd1;
                  if (ok) begin
                     go_ff <= 1'b1;
                  end else begin
                     valid_ff <= 1'b1;
                  end
               end else if (div_done) begin
                  ax_ff <= 2'd0;
               end
            end
            ST_MUL: begin
               ax_ff <= ax_ff + 2'd1;
               if (ax_ff == 2'd3) begin
                  valid_ff <= 1'b1;
               end
            end
            default: ax_ff <= 2'd0;
         endcase
      end
      idx_ff <= idx_in;
      if (state_ff == ST_IDLE && start) begin
         q_ff <= req_query_time;
         n_ff <= n_eff;
      end
      if (state_ff == ST_ALIGN && head.tag == TW'(0)) begin
         prev_ff    <= head.key;
         k0_ff      <= head.key;
         res_ff[0]  <= head.key.kx;
         res_ff[1]  <= head.key.ky;
         res_ff[2]  <= head.key.kz;
         seg_ff     <= '0;
         fault_ff   <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         prev_ff <= head.key;
         if (idx_ff == TW'(0)) begin
            k1_ff <= head.key;
         end
         if (q_ff < head.key.ktime) begin
            s_ff   <= prev_ff;
            e_ff   <= head.key;
            seg_ff <= kvi_pkg::SEG_W'(idx_ff);
         end else if ((CW'(idx_ff) + CW'(2)) == n_ff) begin
            s_ff   <= k0_ff;
            e_ff   <= (idx_ff == TW'(0)) ? head.key : k1_ff;
            seg_ff <= '0;
         end
      end
      if (state_ff == ST_DIV && ax_ff == 2'd0 && !ok) begin
         fault_ff  <= 1'b1;
         res_ff[0] <= '0;
         res_ff[1] <= '0;
         res_ff[2] <= '0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= d_ax * $signed({1'b0, quo});
         if (ax_ff != 2'd0) begin
            res_ff[ax_ff - 2'd1] <= s_ax[ax_ff - 2'd1] + prod_ff[47:16];
         end
      end
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = valid_ff;
   assign rsp_out_x        = res_ff[0];
   assign rsp_out_y        = res_ff[1];
   assign rsp_out_z        = res_ff[2];
   assign rsp_segment      = seg_ff;
   assign rsp_factor_fault = fault_ff;
endmodule

[sv/kvi_checker.sv]
// ----------------------------------------------------------------------------
// kvi_checker
// port-level checks of the keyframe vector interpolator
// ----------------------------------------------------------------------------
`include "keyframe_vector_interpolator_assert.svh"

module kvi_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_action,
   input logic        rsp_valid,
   input logic [31:0] rsp_out_x,
   input logic [31:0] rsp_out_y,
   input logic [31:0] rsp_out_z,
   input logic        rsp_factor_fault
);
   `KVI_ASSERT_NOW(a_fault_zero, clock, reset, rsp_valid && rsp_factor_fault, rsp_out_x == 32'd0 && rsp_out_y == 32'd0 && rsp_out_z == 32'd0)
   `KVI_ASSERT_NEXT(a_query_busy, clock, reset, start && !busy && req_action, busy)
   `KVI_ASSERT_NEXT(a_write_free, clock, reset, start && !busy && !req_action, !busy)
   `KVI_ASSERT_NOW(a_result_idle, clock, reset, rsp_valid, !busy)
endmodule

bind keyframe_vector_interpolator kvi_checker u_kvi_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_out_x        (rsp_out_x),
   .rsp_out_y        (rsp_out_y),
   .rsp_out_z        (rsp_out_z),
   .rsp_factor_fault (rsp_factor_fault)
);
